>>> hw/rtl/msort_pkg.sv
// msort_pkg: shared types and constants of the merge sorter
// command and status structs between msort_ctrl and msort_dp
// no dependencies
`default_nettype none

package msort_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic load;
    logic start;
    logic merge;
    logic emit_mode;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic pass_end;
    logic sort_end;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/msort_ctrl.sv
// msort_ctrl: sequencing state machine of the merge sorter
// load, sort passes and emission; drives msort_dp through cmd_t
// depends on msort_pkg
`default_nettype none

module msort_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  msort_pkg::stat_t stat,
  output msort_pkg::cmd_t  cmd
);
  import msort_pkg::*;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_PRIME   = 3'd2;
  localparam logic [2:0] S_MERGE   = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = stat.n_small ? S_EMIT_RD : S_PRIME;
      end
      S_PRIME: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (stat.sort_end) begin
          state_next = S_EMIT_RD;
        end else if (stat.pass_end) begin
          state_next = S_PRIME;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_mode = 1'b1;
        state_next    = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_mode = 1'b1;
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_next  = stat.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/msort_dp.sv
// msort_dp: datapath of the merge sorter
// two value buffers, run bounds, one comparator and the output register
// depends on msort_pkg; commanded by msort_ctrl
`default_nettype none

module msort_dp #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msort_pkg::cmd_t               cmd,
  output msort_pkg::stat_t              stat,
  input  logic [msort_pkg::DATA_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msort_pkg::DATA_W-1:0]  out_value,
  output logic                          out_final,
  output logic                          out_ovf
);
  import msort_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 2;
  localparam int EW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

  logic [VALUE_WIDTH-1:0] mem_a [DEPTH];
  logic [VALUE_WIDTH-1:0] mem_b [DEPTH];

  logic [CW-1:0] fill, fill_next;
  logic          dropped, dropped_next;
  logic [CW-1:0] w, w_next, lo, lo_next, mid, mid_next, hi, hi_next;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next;
  logic          sel, sel_next;

  logic [VALUE_WIDTH-1:0] a0, a1, b0, b1, ra, rb, wr_val, in_v;
  logic [EW-1:0]          in_ext, out_ext;
  logic [AW-1:0]          rd0, rd1;
  logic                   take_l, merge_end, pass_end, sort_end, room;
  logic [XW-1:0]          lo_adv, w_dbl, n_x;

  function automatic logic [CW-1:0] clip(input logic [XW-1:0] a, input logic [CW-1:0] n);
    logic [XW-1:0] nx;
    nx = XW'(n);
    return (a > nx) ? n : a[CW-1:0];
  endfunction

  assign in_ext = EW'($signed(in_value));
  assign in_v   = in_ext[VALUE_WIDTH-1:0];
  assign ra     = sel ? b0 : a0;
  assign rb     = sel ? b1 : a1;
  assign room   = fill < CW'(DEPTH);
  assign n_x    = XW'(fill);

  always_comb begin
    take_l    = (i < mid) && ((j >= hi) || ($signed(ra) <= $signed(rb)));
    wr_val    = take_l ? ra : rb;
    merge_end = (XW'(k) + XW'(1)) == XW'(hi);
    lo_adv    = XW'(lo) + (XW'(w) << 1);
    w_dbl     = XW'(w) << 1;
    pass_end  = lo_adv >= n_x;
    sort_end  = w_dbl >= n_x;

    fill_next    = fill;
    dropped_next = dropped;
    w_next       = w;
    lo_next      = lo;
    mid_next     = mid;
    hi_next      = hi;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    sel_next     = sel;

    if (cmd.load) begin
      if (room) begin
        fill_next = fill + CW'(1);
      end else begin
        dropped_next = 1'b1;
      end
    end

    if (cmd.start) begin
      w_next   = CW'(1);
      lo_next  = '0;
      i_next   = '0;
      k_next   = '0;
      sel_next = 1'b0;
      mid_next = clip(XW'(1), fill);
      hi_next  = clip(XW'(2), fill);
      j_next   = mid_next;
    end

    if (cmd.merge) begin
      if (!merge_end) begin
        k_next = k + CW'(1);
        if (take_l) begin
          i_next = i + CW'(1);
        end else begin
          j_next = j + CW'(1);
        end
      end else if (!pass_end) begin
        lo_next  = lo_adv[CW-1:0];
        i_next   = lo_adv[CW-1:0];
        k_next   = lo_adv[CW-1:0];
        mid_next = clip(lo_adv + XW'(w), fill);
        hi_next  = clip(lo_adv + w_dbl, fill);
        j_next   = mid_next;
      end else begin
        w_next   = w_dbl[CW-1:0];
        lo_next  = '0;
        i_next   = '0;
        k_next   = '0;
        mid_next = clip(w_dbl, fill);
        hi_next  = clip(w_dbl << 1, fill);
        j_next   = mid_next;
        sel_next = ~sel;
      end
    end

    if (cmd.emit_ld) begin
      k_next = k + CW'(1);
      if (stat.emit_last) begin
        fill_next    = '0;
        dropped_next = 1'b0;
      end
    end

    if (cmd.merge) begin
      rd0 = i_next[AW-1:0];
      rd1 = j_next[AW-1:0];
    end else begin
      rd0 = cmd.emit_mode ? k[AW-1:0] : i[AW-1:0];
      rd1 = j[AW-1:0];
    end
  end

  always_comb begin
    stat.n_small   = fill < CW'(2);
    stat.pass_end  = merge_end && pass_end;
    stat.sort_end  = merge_end && pass_end && sort_end;
    stat.out_free  = !out_valid || out_ready;
    stat.emit_last = (XW'(k) + XW'(1)) == n_x;
  end

  // value buffers
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem_a[fill[AW-1:0]] <= in_v;
    end else if (cmd.merge && sel) begin
      mem_a[k[AW-1:0]] <= wr_val;
    end
    if (cmd.merge && !sel) begin
      mem_b[k[AW-1:0]] <= wr_val;
    end
    a0 <= mem_a[rd0];
    a1 <= mem_a[rd1];
    b0 <= mem_b[rd0];
    b1 <= mem_b[rd1];
  end

  assign out_ext = EW'(ra);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill    <= fill_next;
      dropped <= dropped_next;
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    w   <= w_next;
    lo  <= lo_next;
    mid <= mid_next;
    hi  <= hi_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    sel <= sel_next;
    if (cmd.emit_ld) begin
      out_value <= out_ext[DATA_W-1:0];
      out_final <= stat.emit_last;
      out_ovf   <= stat.emit_last && dropped;
    end
  end

  a_one_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.start, cmd.merge, cmd.emit_ld}))
    else $error("more than one datapath command at once");

  a_merge_bounds : assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> (k < fill) && (i <= mid) && (j <= hi) && (mid <= hi))
    else $error("merge indices out of run bounds");

  a_emit_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |=> out_valid)
    else $error("emitted value not presented");

  a_run_clear : assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld && stat.emit_last |=> (fill == '0) && !dropped)
    else $error("run state not cleared after final value");

endmodule

`default_nettype wire

>>> hw/rtl/merge_sorter.sv
// merge_sorter: buffers a run and emits it sorted ascending by bottom-up merge sort
// load: one item per cycle; sort: ceil(log2 n) passes (one comparator)
// emission: each value is read, then loaded into the output register; tready stalls it
// synchronous active-high reset clears control and fill; value buffers are not cleared
// depends on msort_pkg, msort_ctrl, msort_dp
`default_nettype none

module merge_sorter #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);
  import msort_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msort_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_value  (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_final (m_tlast),
    .out_ovf   (m_tuser)
  );

endmodule

`default_nettype wire
